FILE: design/wbss_pkg.sv
// Shared types, constants and helper functions for the watermark block slot selector.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wbss_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = 13;
  localparam int BLK_W     = 10;
  localparam int TOTAL_W   = 19;
  localparam int MQ_W      = 20;
  localparam int DIV_BITS  = 32;
  localparam int DENS_MAX  = 65536;
  localparam int RECIP3    = 43691;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_DENSITY_Q16   = 3'd2,
    CFG_PERIOD_FRAMES = 3'd3,
    CFG_HASH_SEED     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [16:0] density_q16;
    logic [15:0] period_frames;
    logic [31:0] hash_seed;
  } cfg_t;

  typedef struct packed {
    logic [31:0] frame_number;
    logic [17:0] slot;
  } req_t;

  typedef struct packed {
    logic              selected;
    logic [11:0]       pixel_x;
    logic [11:0]       pixel_y;
    logic signed [1:0] qp_adj;
    logic [18:0]       marks_per_frame;
  } res_t;

  // Item state carried alongside the divider stages.
  typedef struct packed {
    logic [31:0]        frame;
    logic [17:0]        slot;
    logic [TOTAL_W-1:0] total;
    logic [MQ_W-1:0]    mq;
    logic [TOTAL_W-1:0] idx;
    logic [MQ_W-1:0]    marks_q;
  } pipe_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]  rem;
    logic [DIV_BITS-1:0] nq;
  } div_st_t;

  // Clamp a dimension to 1..MAX_DIM and return the count of 8-pixel blocks.
  function automatic logic [BLK_W-1:0] blocks_of(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] c;
    logic [DIM_W:0]   s;
    c = dim;
    if (dim == '0) c = DIM_W'(1);
    else if (dim > DIM_W'(MAX_DIM)) c = DIM_W'(MAX_DIM);
    s = {1'b0, c} + (DIM_W+1)'(7);
    return BLK_W'(s >> 3);
  endfunction

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic div_st_t div_step(input div_st_t cur, input logic [TOTAL_W-1:0] den);
    div_st_t        o;
    logic [TOTAL_W:0] t;
    t = {cur.rem, cur.nq[DIV_BITS-1]};
    if (t >= {1'b0, den}) begin
      o.rem = TOTAL_W'(t - {1'b0, den});
      o.nq  = {cur.nq[DIV_BITS-2:0], 1'b1};
    end else begin
      o.rem = t[TOTAL_W-1:0];
      o.nq  = {cur.nq[DIV_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: design/watermark_block_slot_selector_unit.sv
// Top level of the watermark block slot selector: configuration registers and pipeline.
// Depends on wbss_pkg, wbss_front, wbss_div and wbss_back.
`timescale 1ns / 1ps

// The block picks one 8x8 block of a frame for each request of (frame_number, slot).
// A request is taken at a rising edge where req_valid is high and req_stall is low;
// a result leaves the same way on res_valid and res_stall, one result per request,
// in request order. The result carries whether the slot is marked, the block's
// pixel origin, a QP delta of -1, 0 or +1 and the capped number of marks per frame.
// The pipeline has four front stages (grid, products, sums), three 32-stage
// restoring dividers in series (index modulo block total, mark count over the period,
// and index over blocks per row), and three back stages that end in the result
// register. Throughput is one request per cycle; the divider stages set the latency.
// All stages advance together. When a result waits with res_stall high, the whole
// pipeline holds and req_stall rises, so nothing is lost or repeated. Configuration is
// written through cfg_we, cfg_index and cfg_data while the block is idle, a rule for the
// user that the block does not enforce; unknown indexes are ignored. Synchronous reset
// empties the pipeline and loads width 1920, height 1080, density 0, period 1 and seed 0.
module watermark_block_slot_selector_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  wbss_pkg::req_t req_data,
  output logic           res_valid,
  input  logic           res_stall,
  output wbss_pkg::res_t res_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  wbss_pkg::cfg_t cfg;
  logic           adv;

  logic                 f_valid;
  logic [31:0]          f_raw;
  wbss_pkg::pipe_t      f_side;
  logic                 d1_valid, d2_valid, d3_valid;
  logic [31:0]          d1_quo, d2_quo, d3_quo;
  logic [18:0]          d1_rem, d2_rem, d3_rem;
  wbss_pkg::pipe_t      d1_side, d2_side, d3_side;
  wbss_pkg::pipe_t      d1_out, d2_out;
  logic [18:0]          per_den, bx_den;

  // The pipeline moves whenever the result register is free or being taken.
  assign adv       = !(res_valid && res_stall);
  assign req_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= 13'd1920;
      cfg.frame_height  <= 13'd1080;
      cfg.density_q16   <= '0;
      cfg.period_frames <= 16'd1;
      cfg.hash_seed     <= '0;
    end else if (cfg_we) begin
      case (wbss_pkg::cfg_idx_t'(cfg_index))
        wbss_pkg::CFG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[12:0];
        wbss_pkg::CFG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[12:0];
        wbss_pkg::CFG_DENSITY_Q16:   cfg.density_q16   <= cfg_data[16:0];
        wbss_pkg::CFG_PERIOD_FRAMES: cfg.period_frames <= cfg_data[15:0];
        wbss_pkg::CFG_HASH_SEED:     cfg.hash_seed     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Divisors stay fixed in flight only if the user configures when idle; nothing enforces it.
  assign per_den = {3'b0, (cfg.period_frames == '0) ? 16'd1 : cfg.period_frames};
  assign bx_den  = {9'b0, wbss_pkg::blocks_of(cfg.frame_width)};

  wbss_front u_front (
    .clk(clk), .rst(rst), .en(adv), .cfg(cfg),
    .in_valid(req_valid), .in_req(req_data),
    .out_valid(f_valid), .out_raw(f_raw), .out_side(f_side)
  );

  // Block index: raw index modulo the block total.
  wbss_div u_div_idx (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f_valid),
    .num(f_raw), .den(f_side.total), .in_side(f_side),
    .out_valid(d1_valid), .quo(d1_quo), .rem(d1_rem), .out_side(d1_side)
  );

  always_comb begin
    d1_out     = d1_side;
    d1_out.idx = d1_rem;
  end

  // Marks per frame before the cap: scaled count over the period.
  wbss_div u_div_marks (
    .clk(clk), .rst(rst), .en(adv), .in_valid(d1_valid),
    .num({12'b0, d1_side.mq}), .den(per_den), .in_side(d1_out),
    .out_valid(d2_valid), .quo(d2_quo), .rem(d2_rem), .out_side(d2_side)
  );

  always_comb begin
    d2_out         = d2_side;
    d2_out.marks_q = d2_quo[19:0];
  end

  // Block column and row: index over blocks per row.
  wbss_div u_div_xy (
    .clk(clk), .rst(rst), .en(adv), .in_valid(d2_valid),
    .num({13'b0, d2_side.idx}), .den(bx_den), .in_side(d2_out),
    .out_valid(d3_valid), .quo(d3_quo), .rem(d3_rem), .out_side(d3_side)
  );

  wbss_back u_back (
    .clk(clk), .rst(rst), .en(adv), .seed(cfg.hash_seed),
    .in_valid(d3_valid), .blk_y(d3_quo), .blk_x(d3_rem), .in_side(d3_side),
    .out_valid(res_valid), .out_res(res_data)
  );

endmodule

FILE: design/wbss_front.sv
// Front stages: block grid, raw block index and scaled mark count numerator.
// Depends on wbss_pkg.
`timescale 1ns / 1ps

module wbss_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  wbss_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  wbss_pkg::req_t in_req,
  output logic           out_valid,
  output logic [31:0]    out_raw,
  output wbss_pkg::pipe_t out_side
);

  logic [3:0]  v;
  logic [31:0] frame1, frame2, frame3, frame4;
  logic [17:0] slot1, slot2, slot3, slot4;
  logic [wbss_pkg::BLK_W-1:0]   bx1, by1;
  logic [wbss_pkg::TOTAL_W-1:0] total2, total3, total4;
  logic [31:0] prod2, raw3, raw4;
  logic [35:0] md3;
  logic [wbss_pkg::MQ_W-1:0]    mq4;
  logic [15:0] per;
  logic [16:0] dens;
  logic [33:0] prod_full;

  always_comb begin
    per  = (cfg.period_frames == '0) ? 16'd1 : cfg.period_frames;
    dens = (cfg.density_q16 > 17'(wbss_pkg::DENS_MAX)) ? 17'(wbss_pkg::DENS_MAX)
                                                        : cfg.density_q16;
    prod_full = {16'b0, slot1} * {18'b0, per};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame1 <= in_req.frame_number;
      slot1  <= in_req.slot;
      bx1    <= wbss_pkg::blocks_of(cfg.frame_width);
      by1    <= wbss_pkg::blocks_of(cfg.frame_height);
      frame2 <= frame1;
      slot2  <= slot1;
      total2 <= {9'b0, bx1} * {9'b0, by1};
      prod2  <= prod_full[31:0];
      frame3 <= frame2;
      slot3  <= slot2;
      total3 <= total2;
      raw3   <= frame2 + prod2;
      md3    <= {17'b0, total2} * {19'b0, dens};
      frame4 <= frame3;
      slot4  <= slot3;
      total4 <= total3;
      raw4   <= raw3;
      mq4    <= md3[35:16];
    end
  end

  assign out_valid = v[3];
  assign out_raw   = raw4;
  assign out_side  = '{frame: frame4, slot: slot4, total: total4, mq: mq4,
                       idx: '0, marks_q: '0};

endmodule

FILE: design/wbss_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on wbss_pkg.
`timescale 1ns / 1ps

module wbss_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [wbss_pkg::DIV_BITS-1:0]  num,
  input  logic [wbss_pkg::TOTAL_W-1:0]   den,
  input  wbss_pkg::pipe_t                in_side,
  output logic                           out_valid,
  output logic [wbss_pkg::DIV_BITS-1:0]  quo,
  output logic [wbss_pkg::TOTAL_W-1:0]   rem,
  output wbss_pkg::pipe_t                out_side
);

  localparam int N = wbss_pkg::DIV_BITS;

  logic [N-1:0]      v;
  wbss_pkg::div_st_t st   [N];
  wbss_pkg::pipe_t   side [N];
  wbss_pkg::div_st_t first;

  assign first = '{rem: '0, nq: num};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0]   <= wbss_pkg::div_step(first, den);
      side[0] <= in_side;
      for (int k = 1; k < N; k++) begin
        st[k]   <= wbss_pkg::div_step(st[k-1], den);
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = v[N-1];
  assign quo       = st[N-1].nq;
  assign rem       = st[N-1].rem;
  assign out_side  = side[N-1];

endmodule

FILE: design/wbss_back.sv
// Back stages: mark cap, slot test, QP hash modulo 3 and the result register.
// Depends on wbss_pkg.
`timescale 1ns / 1ps

module wbss_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [31:0]                  seed,
  input  logic                         in_valid,
  input  logic [wbss_pkg::DIV_BITS-1:0] blk_y,
  input  logic [wbss_pkg::TOTAL_W-1:0] blk_x,
  input  wbss_pkg::pipe_t              in_side,
  output logic                         out_valid,
  output wbss_pkg::res_t               out_res
);

  logic [2:0]  v;
  logic        sel1, sel2;
  logic [18:0] marks1, marks2;
  logic [11:0] px1, py1, px2, py2;
  logic [31:0] h1;
  logic [12:0] hs2;
  logic [11:0] hq2;
  logic [18:0] marks_cap;
  logic [12:0] hs_next;
  logic [28:0] hprod;
  logic [12:0] m3;
  logic [1:0]  qp;

  always_comb begin
    marks_cap = (in_side.marks_q > {1'b0, in_side.total}) ? in_side.total
                                                          : in_side.marks_q[18:0];
    hs_next = h1[18:6] ^ h1[31:19];
    hprod   = {16'b0, hs_next} * 29'(wbss_pkg::RECIP3);
    m3      = 13'(hs2 - 13'({1'b0, hq2} * 13'd3));
    case (m3[1:0])
      2'd0:    qp = 2'b11;
      2'd1:    qp = 2'b00;
      2'd2:    qp = 2'b01;
      default: qp = 2'b00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      marks1 <= marks_cap;
      sel1   <= {1'b0, in_side.slot} < marks_cap;
      px1    <= {blk_x[8:0], 3'b000};
      py1    <= {blk_y[8:0], 3'b000};
      h1     <= {13'b0, in_side.idx} * 32'd31 + in_side.frame * 32'd17 + seed;
      marks2 <= marks1;
      sel2   <= sel1;
      px2    <= px1;
      py2    <= py1;
      hs2    <= hs_next;
      hq2    <= hprod[28:17];
      out_res.marks_per_frame <= marks2;
      out_res.selected        <= sel2;
      out_res.pixel_x         <= sel2 ? px2 : 12'd0;
      out_res.pixel_y         <= sel2 ? py2 : 12'd0;
      out_res.qp_adj          <= sel2 ? qp : 2'b00;
    end
  end

  assign out_valid = v[2];

endmodule

FILE: design/wbss_chk.sv
// Port-level checker for the watermark block slot selector, bound to the top level.
// Depends on wbss_pkg and watermark_block_slot_selector_unit.
`timescale 1ns / 1ps

module wbss_chk (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           res_valid,
  input logic           res_stall,
  input wbss_pkg::res_t res_data
);

  // An unmarked slot carries no block position and no QP delta.
  a_unsel_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.selected) |->
      (res_data.pixel_x == 12'd0 && res_data.pixel_y == 12'd0 && res_data.qp_adj == 2'sb00))
    else $error("unselected result has nonzero fields");

  // The QP delta is never -2 and block origins sit on the 8-pixel grid.
  a_qp_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.qp_adj != 2'sb10 && res_data.pixel_x[2:0] == 3'd0
                   && res_data.pixel_y[2:0] == 3'd0))
    else $error("qp_adj or block origin out of range");

  // A held result holds the input side as well.
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |-> req_stall)
    else $error("request taken while result stalled");

  // A stalled result stays until taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");

endmodule

bind watermark_block_slot_selector_unit wbss_chk u_wbss_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
);

FILE: tb/watermark_block_slot_selector_unit_test.sv
// Self-checking testbench for the watermark block slot selector unit.
// Depends on wbss_pkg and watermark_block_slot_selector_unit.
`timescale 1ns / 1ps

module watermark_block_slot_selector_unit_test;

  // Quiet periods are sized well above the block latency.
  localparam int SETTLE_CYCLES    = 200;
  localparam int LONG_HOLD_CYCLES = 300;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  wbss_pkg::req_t req_data;
  logic           res_valid;
  logic           res_stall;
  wbss_pkg::res_t res_data;
  logic           cfg_we;
  logic [2:0]     cfg_index;
  logic [31:0]    cfg_data;

  // Our own copy of the configuration registers, as the block holds them.
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [16:0] density_reg;
  logic [15:0] period_reg;
  logic [31:0] seed_reg;

  wbss_pkg::res_t pending_results[$];
  int   error_count;
  bit   rx_idle_enable;
  bit   rx_long_hold;
  int   rx_hold_cycles;
  int   rx_long_count;

  watermark_block_slot_selector_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predict the result of one request from the current register copies.
  function automatic wbss_pkg::res_t select_block(input logic [31:0] frame,
                                                  input logic [17:0] slot);
    wbss_pkg::res_t r;
    logic [31:0] w, h, dens, per, bx, by, total, raw, idx, hv, m;
    logic [63:0] marks64;
    logic [31:0] marks;
    w = width_reg;
    h = height_reg;
    if (w == 0) w = 1;
    else if (w > wbss_pkg::MAX_DIM) w = wbss_pkg::MAX_DIM;
    if (h == 0) h = 1;
    else if (h > wbss_pkg::MAX_DIM) h = wbss_pkg::MAX_DIM;
    dens = (density_reg > wbss_pkg::DENS_MAX) ? wbss_pkg::DENS_MAX : density_reg;
    per = (period_reg == 0) ? 1 : period_reg;
    bx = (w + 7) / 8;
    by = (h + 7) / 8;
    total = bx * by;
    marks64 = (64'(total) * 64'(dens)) / (64'(per) << 16);
    marks = (marks64 > 64'(total)) ? total : marks64[31:0];
    r = '0;
    if (32'(slot) < marks) begin
      raw = frame + 32'(slot) * per;
      idx = raw % total;
      hv = idx * 32'd31 + frame * 32'd17 + seed_reg;
      hv = ((hv << 13) ^ hv) >> 19;
      m = hv % 3;
      r.selected = 1'b1;
      r.pixel_x = 12'((idx % bx) * 8);
      r.pixel_y = 12'((idx / bx) * 8);
      r.qp_adj = (m == 0) ? -2'sd1 : ((m == 1) ? 2'sd0 : 2'sd1);
    end
    r.marks_per_frame = 19'(marks);
    return r;
  endfunction

  // Write one register while the block is idle and mirror it locally.
  task automatic write_reg(input wbss_pkg::cfg_idx_t which, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    case (which)
      wbss_pkg::CFG_FRAME_WIDTH: begin
        width_reg = value[12:0];
      end
      wbss_pkg::CFG_FRAME_HEIGHT: begin
        height_reg = value[12:0];
      end
      wbss_pkg::CFG_DENSITY_Q16: begin
        density_reg = value[16:0];
      end
      wbss_pkg::CFG_PERIOD_FRAMES: begin
        period_reg = value[15:0];
      end
      default: begin
        seed_reg = value;
      end
    endcase
  endtask

  task automatic set_config(input logic [31:0] w, input logic [31:0] h, input logic [31:0] d,
                            input logic [31:0] p, input logic [31:0] s);
    write_reg(wbss_pkg::CFG_FRAME_WIDTH, w);
    write_reg(wbss_pkg::CFG_FRAME_HEIGHT, h);
    write_reg(wbss_pkg::CFG_DENSITY_Q16, d);
    write_reg(wbss_pkg::CFG_PERIOD_FRAMES, p);
    write_reg(wbss_pkg::CFG_HASH_SEED, s);
    cfg_we <= 1'b0;
  endtask

  // Offer one request, optionally after a random idle burst, and hold it until taken.
  task automatic send_request(input logic [31:0] frame, input logic [17:0] slot,
                              input bit allow_idle);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= '{frame_number: frame, slot: slot};
    pending_results = {pending_results, select_block(frame, slot)};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    req_valid <= 1'b0;
  endtask

  // Wait until every expected result has arrived, then let the pipeline drain.
  task automatic drain();
    go_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Slot at the mark count boundary and a few around it.
  task automatic test_directed();
    set_config(64, 64, 65536, 1, 32'h0000_0000);
    send_request(32'h0, 18'h0, 0);
    send_request(32'hFFFF_FFFF, 18'd63, 0);
    send_request(32'h1234_5678, 18'd64, 0);
    send_request(32'hFFFF_FFFF, 18'h3FFFF, 0);
    drain();
    // Dimensions beyond the limit and zero saturate, density over one saturates.
    set_config(32'h1FFF, 0, 32'h1FFFF, 0, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFF0, 18'd0, 0);
    send_request(32'd7, 18'd511, 0);
    send_request(32'hAAAA_AAAA, 18'h2AAAA, 0);
    send_request(32'h5555_5555, 18'h15555, 0);
    drain();
    // Largest grid at full density, with a long period and a period of one; index wraps at 32 bits.
    set_config(4096, 4096, 65536, 65535, 32'h8000_0001);
    send_request(32'hFFFF_FFFF, 18'd0, 0);
    drain();
    set_config(4096, 4096, 65536, 1, 32'h8000_0001);
    send_request(32'hFFFF_FFFF, 18'h3FFFF, 0);
    send_request(32'hFFFF_0000, 18'h3FFFE, 0);
    drain();
    // Smallest frame, first with the tiniest density and a large period, then at full density.
    set_config(1, 1, 1, 65535, 32'h1);
    send_request(32'h0, 18'h0, 0);
    drain();
    set_config(1, 1, 65536, 1, 32'h1);
    send_request(32'h0, 18'h0, 0);
    send_request(32'h8000_0000, 18'h1, 0);
    drain();
  endtask

  // Random configurations, mostly high density and short periods with selectable slots.
  task automatic test_random(input int count, input bit allow_idle);
    int          i;
    logic [31:0] frame;
    logic [17:0] slot;
    for (i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        drain();
        set_config($urandom_range(0, 8191), $urandom_range(0, 8191),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                               : $urandom_range(30000, 65536),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(1, 4),
                   $urandom());
      end
      frame = $urandom();
      if ($urandom_range(0, 4) == 0) slot = 18'($urandom());
      else slot = 18'($urandom_range(0, 2000));
      send_request(frame, slot, allow_idle);
    end
    drain();
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    int i;
    set_config(640, 480, 65536, 1, 32'hDEAD_BEEF);
    rx_long_hold = 1'b1;
    for (i = 0; i < 150; i++) send_request($urandom(), 18'($urandom_range(0, 5000)), 0);
    drain();
    rx_long_hold = 1'b0;
  endtask

  // Receiver: random stall bursts, or a long counted hold when requested.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      rx_hold_cycles <= 0;
      rx_long_count <= 0;
    end else if (rx_long_hold && rx_long_count < LONG_HOLD_CYCLES) begin
      res_stall <= 1'b1;
      rx_long_count <= rx_long_count + 1;
    end else if (rx_hold_cycles > 0) begin
      res_stall <= 1'b1;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else if (rx_idle_enable && !res_stall && $urandom_range(0, 5) == 0) begin
      res_stall <= 1'b1;
      rx_hold_cycles <= $urandom_range(0, 6);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    wbss_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", res_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_data.selected !== want.selected) begin
          $error("selected: expected %0d, got %0d", want.selected, res_data.selected);
          error_count++;
        end
        if (res_data.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, res_data.pixel_x);
          error_count++;
        end
        if (res_data.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, res_data.pixel_y);
          error_count++;
        end
        if (res_data.qp_adj !== want.qp_adj) begin
          $error("qp_adj: expected %0d, got %0d", want.qp_adj, res_data.qp_adj);
          error_count++;
        end
        if (res_data.marks_per_frame !== want.marks_per_frame) begin
          $error("marks_per_frame: expected %0d, got %0d", want.marks_per_frame,
                 res_data.marks_per_frame);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("** watermark_block_slot_selector_unit: FAILED **");
    $finish;
  end

  initial begin
    error_count = 0;
    rx_idle_enable = 1'b0;
    rx_long_hold = 1'b0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= wbss_pkg::CFG_FRAME_WIDTH;
    cfg_data <= '0;
    width_reg = 1920;
    height_reg = 1080;
    density_reg = 0;
    period_reg = 1;
    seed_reg = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    // Reset values give a zero mark count, so nothing is selected.
    send_request(32'h1, 18'h0, 0);
    drain();
    test_directed();
    rx_idle_enable = 1'b1;
    test_random(500, 1);
    test_backpressure();
    rx_idle_enable = 1'b0;
    test_random(200, 0);
    if (error_count == 0) begin
      $display("** watermark_block_slot_selector_unit: PASSED **");
    end else begin
      $display("** watermark_block_slot_selector_unit: FAILED **");
    end
    $finish;
  end

endmodule
